// ===== design/tkbt_pkg.sv =====
// shared types and constants of the touch key baseline tracker
package tkbt_pkg;

  localparam int MaxChannels = 16;
  localparam int SampleWidth = 16;
  localparam int ChanW       = $clog2(MaxChannels);
  localparam int CntW        = 8;
  localparam int ActiveW     = 5;

  // counter codes of the stability window
  localparam logic [CntW-1:0] WindowThresh = 8'h80;
  localparam logic [CntW-1:0] WindowOpen   = 8'h81;
  localparam logic [CntW-1:0] CntMax       = 8'hFF;

  // register indexes on the configuration port
  localparam logic [2:0] RegChannelCount   = 3'd0;
  localparam logic [2:0] RegReferenceEnable = 3'd1;
  localparam logic [2:0] RegUpperLimit     = 3'd2;
  localparam logic [2:0] RegLowerLimit     = 3'd3;
  localparam logic [2:0] RegUpdateTime     = 3'd4;

  typedef struct packed {
    logic [3:0] channel_count;
    logic       reference_enable;
    logic [7:0] upper_limit;
    logic [7:0] lower_limit;
    logic [7:0] update_time;
  } cfg_t;

  // one entry of the per-channel state memory
  typedef struct packed {
    logic [CntW-1:0]        cnt;
    logic [SampleWidth-1:0] basepoint;
    logic [SampleWidth-1:0] baseline;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [ChanW-1:0] addr;
    entry_t           data;
  } wr_t;

endpackage

// ===== design/tkbt_cfg.sv =====
// configuration registers behind the apb-style port
module tkbt_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output tkbt_pkg::cfg_t    cfg_o
);

  tkbt_pkg::cfg_t cfg_q;
  logic           wr_en;
  logic [2:0]     reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign cfg_o   = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.channel_count    <= 4'd1;
      cfg_q.reference_enable <= 1'b0;
      cfg_q.upper_limit      <= 8'd0;
      cfg_q.lower_limit      <= 8'd0;
      cfg_q.update_time      <= 8'hFF;
    end else if (wr_en) begin
      unique case (reg_idx)
        tkbt_pkg::RegChannelCount:    cfg_q.channel_count    <= pwdata[3:0];
        tkbt_pkg::RegReferenceEnable: cfg_q.reference_enable <= pwdata[0];
        tkbt_pkg::RegUpperLimit:      cfg_q.upper_limit      <= pwdata[7:0];
        tkbt_pkg::RegLowerLimit:      cfg_q.lower_limit      <= pwdata[7:0];
        tkbt_pkg::RegUpdateTime:      cfg_q.update_time      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (reg_idx)
      tkbt_pkg::RegChannelCount:    prdata = {28'd0, cfg_q.channel_count};
      tkbt_pkg::RegReferenceEnable: prdata = {31'd0, cfg_q.reference_enable};
      tkbt_pkg::RegUpperLimit:      prdata = {24'd0, cfg_q.upper_limit};
      tkbt_pkg::RegLowerLimit:      prdata = {24'd0, cfg_q.lower_limit};
      tkbt_pkg::RegUpdateTime:      prdata = {24'd0, cfg_q.update_time};
      default:                      prdata = 32'd0;
    endcase
  end

endmodule

// ===== design/tkbt_mem.sv =====
// per-channel state memory with entry valid bits and write forwarding
module tkbt_mem (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [tkbt_pkg::ChanW-1:0]    rd_addr_i,
  input  tkbt_pkg::wr_t                 wr_i,
  output tkbt_pkg::entry_t              rd_data_o
);

  tkbt_pkg::entry_t                      mem [tkbt_pkg::MaxChannels];
  tkbt_pkg::entry_t                      mem_rd_q;
  tkbt_pkg::entry_t                      fwd_q;
  logic                                  hit_q;
  logic                                  vld_q;
  logic [tkbt_pkg::MaxChannels-1:0]      valid_q;
  logic                                  hit;

  assign hit = wr_i.en && (wr_i.addr == rd_addr_i);

  // synchronous write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      mem_rd_q <= mem[rd_addr_i];
      fwd_q    <= wr_i.data;
    end
  end

  // entry valid bits; an entry never written reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      hit_q   <= 1'b0;
      vld_q   <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        hit_q <= hit;
        vld_q <= valid_q[rd_addr_i];
      end
    end
  end

  // same-entry write in the read cycle wins over the array
  always_comb begin
    if (hit_q) begin
      rd_data_o = fwd_q;
    end else if (vld_q) begin
      rd_data_o = mem_rd_q;
    end else begin
      rd_data_o = '0;
    end
  end

endmodule

// ===== design/tkbt_update.sv =====
// stability window, baseline update and set bookkeeping for one beat
module tkbt_update (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tkbt_pkg::cfg_t                      cfg_i,
  input  tkbt_pkg::entry_t                    cur_i,
  input  logic [tkbt_pkg::ChanW-1:0]          channel_i,
  input  logic [tkbt_pkg::SampleWidth-1:0]    raw_i,
  input  logic                                touch_i,
  input  logic                                invalid_i,
  input  logic                                commit_i,
  output tkbt_pkg::wr_t                       wr_o,
  output logic [tkbt_pkg::SampleWidth-1:0]    baseline_o,
  output logic                                updated_o,
  output logic                                all_set_o
);

  logic [tkbt_pkg::MaxChannels-1:0] mask_q, mask_d;
  logic [tkbt_pkg::ActiveW-1:0]     count_q, count_d;
  logic                             flag_q, flag_d;
  logic [tkbt_pkg::ActiveW-1:0]     active;
  logic                             ch_active;
  tkbt_pkg::entry_t                 nxt;
  logic                             upd;
  logic                             over, under;
  logic [tkbt_pkg::SampleWidth-1:0] rise, fall;

  assign active    = {1'b0, cfg_i.channel_count} + {4'd0, cfg_i.reference_enable};
  assign ch_active = {1'b0, channel_i} < active;

  // distance of the sample from the basepoint
  assign rise  = raw_i - cur_i.basepoint;
  assign fall  = cur_i.basepoint - raw_i;
  assign over  = (raw_i > cur_i.basepoint) &&
                 (rise > {{(tkbt_pkg::SampleWidth-8){1'b0}}, cfg_i.upper_limit});
  assign under = (cur_i.basepoint > raw_i) &&
                 (fall > {{(tkbt_pkg::SampleWidth-8){1'b0}}, cfg_i.lower_limit});

  // counter and baseline next values
  always_comb begin
    nxt = cur_i;
    upd = 1'b0;
    if (touch_i || invalid_i) begin
      nxt.cnt = '0;
    end else begin
      if (cur_i.baseline != raw_i) begin
        if (cur_i.cnt < tkbt_pkg::WindowThresh) begin
          nxt.cnt       = tkbt_pkg::WindowOpen;
          nxt.basepoint = raw_i;
        end else begin
          if (cur_i.cnt != tkbt_pkg::CntMax) begin
            nxt.cnt = cur_i.cnt + 8'd1;
          end
          if (over || under) begin
            nxt.cnt = '0;
          end
        end
      end
      if (nxt.cnt >= cfg_i.update_time) begin
        nxt.cnt      = '0;
        nxt.baseline = raw_i;
        upd          = 1'b1;
      end
    end
    if (!ch_active) begin
      nxt = cur_i;
      upd = 1'b0;
    end
  end

  // first-update bookkeeping
  always_comb begin
    mask_d  = mask_q;
    count_d = count_q;
    flag_d  = flag_q;
    if (upd && !flag_q && !mask_q[channel_i]) begin
      mask_d[channel_i] = 1'b1;
      count_d           = count_q + 5'd1;
      if (count_d >= active) begin
        flag_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q  <= '0;
      count_q <= '0;
      flag_q  <= 1'b0;
    end else if (commit_i) begin
      mask_q  <= mask_d;
      count_q <= count_d;
      flag_q  <= flag_d;
    end
  end

  assign wr_o.en    = commit_i && ch_active;
  assign wr_o.addr  = channel_i;
  assign wr_o.data  = nxt;
  assign baseline_o = nxt.baseline;
  assign updated_o  = upd;
  assign all_set_o  = flag_d;

endmodule

// ===== design/touch_key_baseline_tracker_top.sv =====
// top level of the touch key baseline tracker
// stages: update stage, then output register; one beat per cycle while the output
//   does not stall; the state memory read is issued at accept and the write-back as
//   the update stage advances, with forwarding when the same channel follows directly
// reset: entry valid bits clear at once so all channel state reads as zero, no
//   clearing pass; registers return to channel_count 1, update_time 255, others 0
module touch_key_baseline_tracker_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  channel_i,
  input  logic [15:0] raw_sample_i,
  input  logic        touch_active_i,
  input  logic        raw_invalid_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  out_channel_o,
  output logic [15:0] baseline_value_o,
  output logic        baseline_updated_o,
  output logic        all_baselines_set_o
);

  tkbt_pkg::cfg_t                      cfg;
  tkbt_pkg::entry_t                    cur;
  tkbt_pkg::wr_t                       wr;
  logic                                accept;
  logic                                out_free;
  logic                                s1_adv;
  logic                                s1_valid_q, s1_valid_d;
  logic                                out_valid_q, out_valid_d;
  logic [tkbt_pkg::ChanW-1:0]          s1_ch_q;
  logic [tkbt_pkg::SampleWidth-1:0]    s1_raw_q;
  logic                                s1_touch_q;
  logic                                s1_inval_q;
  logic [tkbt_pkg::SampleWidth-1:0]    res_base;
  logic                                res_upd;
  logic                                res_all;
  logic [3:0]                          out_ch_q;
  logic [15:0]                         out_base_q;
  logic                                out_upd_q;
  logic                                out_all_q;

  tkbt_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // handshake and pipeline advance
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  tkbt_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (channel_i),
    .wr_i      (wr),
    .rd_data_o (cur)
  );

  tkbt_update u_update (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .cur_i      (cur),
    .channel_i  (s1_ch_q),
    .raw_i      (s1_raw_q),
    .touch_i    (s1_touch_q),
    .invalid_i  (s1_inval_q),
    .commit_i   (s1_adv),
    .wr_o       (wr),
    .baseline_o (res_base),
    .updated_o  (res_upd),
    .all_set_o  (res_all)
  );

  // valid flags of the update stage and the output register
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q && out_stall_i;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // update stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ch_q    <= channel_i;
      s1_raw_q   <= raw_sample_i[tkbt_pkg::SampleWidth-1:0];
      s1_touch_q <= touch_active_i;
      s1_inval_q <= raw_invalid_i;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_ch_q   <= s1_ch_q;
      out_base_q <= 16'(res_base);
      out_upd_q  <= res_upd;
      out_all_q  <= res_all;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_channel_o       = out_ch_q;
  assign baseline_value_o    = out_base_q;
  assign baseline_updated_o  = out_upd_q;
  assign all_baselines_set_o = out_all_q;

endmodule

// ===== test/touch_key_baseline_tracker_top_test.sv =====
// self-checking testbench of the touch key baseline tracker top level
module touch_key_baseline_tracker_top_test;
  import tkbt_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 4;

  typedef struct packed {
    logic [3:0]  channel;
    logic [15:0] baseline;
    logic        updated;
    logic        all_set;
  } baseline_report_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [3:0]  channel_i = '0;
  logic [15:0] raw_sample_i = '0;
  logic        touch_active_i = 1'b0;
  logic        raw_invalid_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [3:0]  out_channel_o;
  logic [15:0] baseline_value_o;
  logic        baseline_updated_o;
  logic        all_baselines_set_o;

  touch_key_baseline_tracker_top DUT (.*);

  // mirror of the registers and the per-channel tracking state
  cfg_t                   reg_mirror;
  logic [CntW-1:0]        win_count  [MaxChannels];
  logic [SampleWidth-1:0] win_anchor [MaxChannels];
  logic [SampleWidth-1:0] base_mem   [MaxChannels];
  logic [MaxChannels-1:0] set_mask;
  int                     set_total;
  logic                   all_set;

  baseline_report_t pending_reports[$];
  int failures = 0;
  int cycle_count = 0;
  int src_gap_pct = 0;
  int sink_stall_pct = 0;
  int stall_hold = 0;

  initial begin
    reg_mirror = '{channel_count: 4'd1, reference_enable: 1'b0, upper_limit: 8'd0,
                   lower_limit: 8'd0, update_time: 8'hFF};
    win_count = '{default: '0};
    win_anchor = '{default: '0};
    base_mem = '{default: '0};
    set_mask = '0;
    set_total = 0;
    all_set = 1'b0;
  end

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver stalls, with a long hold-off while stall_hold counts down
  always @(posedge clk_i) begin
    if (stall_hold != 0) stall_hold <= stall_hold - 1;
    out_stall_i <= (stall_hold > 1) || ($urandom_range(99) < sink_stall_pct);
  end

  // expected baseline report for one accepted sample
  function automatic baseline_report_t predict_baseline(input logic [3:0] ch,
      input logic [15:0] raw, input logic touch, input logic invalid);
    baseline_report_t rep;
    int active;
    int diff;
    active = int'(reg_mirror.channel_count) + int'(reg_mirror.reference_enable);
    rep.updated = 1'b0;
    if (int'(ch) < active) begin
      if (touch || invalid) begin
        win_count[ch] = '0;
      end else begin
        if (base_mem[ch] != raw) begin
          if (win_count[ch] < WindowThresh) begin
            win_count[ch] = WindowOpen;
            win_anchor[ch] = raw;
          end else begin
            if (win_count[ch] != CntMax) win_count[ch] = win_count[ch] + 1'b1;
            diff = int'(raw) - int'(win_anchor[ch]);
            if (diff > int'(reg_mirror.upper_limit) || diff < -int'(reg_mirror.lower_limit))
              win_count[ch] = '0;
          end
        end
        if (win_count[ch] >= reg_mirror.update_time) begin
          win_count[ch] = '0;
          base_mem[ch] = raw;
          rep.updated = 1'b1;
          // first baseline of a channel counts toward the all-set flag
          if (!all_set && !set_mask[ch]) begin
            set_mask[ch] = 1'b1;
            set_total++;
            if (set_total >= active) all_set = 1'b1;
          end
        end
      end
    end
    rep.channel = ch;
    rep.baseline = base_mem[ch];
    rep.all_set = all_set;
    return rep;
  endfunction

  // result beat checker
  always @(posedge clk_i) begin
    baseline_report_t exp_rep;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected result beat on channel %0d", out_channel_o);
        failures++;
      end else begin
        exp_rep = pending_reports.pop_front();
        if (out_channel_o !== exp_rep.channel) begin
          $error("out_channel: expected %0d, got %0d", exp_rep.channel, out_channel_o);
          failures++;
        end
        if (baseline_value_o !== exp_rep.baseline) begin
          $error("baseline_value: expected %h, got %h", exp_rep.baseline, baseline_value_o);
          failures++;
        end
        if (baseline_updated_o !== exp_rep.updated) begin
          $error("baseline_updated: expected %b, got %b", exp_rep.updated, baseline_updated_o);
          failures++;
        end
        if (all_baselines_set_o !== exp_rep.all_set) begin
          $error("all_baselines_set: expected %b, got %b", exp_rep.all_set,
                 all_baselines_set_o);
          failures++;
        end
      end
    end
  end

  // one input beat, with random gaps in front of it
  task automatic send_sample(input logic [3:0] ch, input logic [15:0] raw,
      input logic touch, input logic invalid);
    while ($urandom_range(99) < src_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    channel_i <= ch;
    raw_sample_i <= raw;
    touch_active_i <= touch;
    raw_invalid_i <= invalid;
    do @(posedge clk_i); while (in_stall_o);
    pending_reports.push_back(predict_baseline(ch, raw, touch, invalid));
  endtask

  task automatic send_stray_beat();
    send_sample(4'($urandom_range(15)), 16'($urandom_range(16'hFFFF)),
                1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  task automatic set_pacing(input int src_pct, input int sink_pct);
    src_gap_pct <= src_pct;
    sink_stall_pct <= sink_pct;
  endtask

  // stop offering beats and wait until every report is back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // register write with a read-back check
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    logic [31:0] kept;
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      RegChannelCount: reg_mirror.channel_count = value[3:0];
      RegReferenceEnable: reg_mirror.reference_enable = value[0];
      RegUpperLimit: reg_mirror.upper_limit = value[7:0];
      RegLowerLimit: reg_mirror.lower_limit = value[7:0];
      RegUpdateTime: reg_mirror.update_time = value[7:0];
      default: ;
    endcase
    case (idx)
      RegChannelCount: kept = {28'd0, value[3:0]};
      RegReferenceEnable: kept = {31'd0, value[0]};
      default: kept = {24'd0, value[7:0]};
    endcase
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== kept) begin
      $error("register %0d: expected %h, got %h", idx, kept, prdata);
      failures++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic program_config(input int chans, input int ref_en, input int upper,
      input int lower, input int upd_time);
    wait_drained();
    write_reg(RegChannelCount, chans);
    write_reg(RegReferenceEnable, ref_en);
    write_reg(RegUpperLimit, upper);
    write_reg(RegLowerLimit, lower);
    write_reg(RegUpdateTime, upd_time);
  endtask

  function automatic logic [15:0] clamp_sample(input int v);
    if (v < 0) return 16'h0000;
    if (v > 16'hFFFF) return 16'hFFFF;
    return v[15:0];
  endfunction

  // bursts of settled samples on active channels, mixed with stray beats
  task automatic run_traffic(input int beats);
    int sent, active, anchor, len, r, lo, hi;
    logic [3:0] ch;
    sent = 0;
    active = int'(reg_mirror.channel_count) + int'(reg_mirror.reference_enable);
    lo = int'(reg_mirror.lower_limit);
    hi = int'(reg_mirror.upper_limit);
    while (sent < beats) begin
      if ($urandom_range(99) < 20) begin
        send_stray_beat();
        sent++;
      end else begin
        ch = 4'($urandom_range(active - 1));
        // keep an open window going, else start one on a fresh level
        anchor = (win_count[ch] >= WindowThresh) ? int'(win_anchor[ch])
                                                 : int'($urandom_range(16'hFFFF));
        len = 1 + $urandom_range(2);
        if (reg_mirror.update_time > WindowOpen)
          len += int'(reg_mirror.update_time) - int'(WindowOpen);
        for (int k = 0; k < len && sent < beats; k++) begin
          if ($urandom_range(99) < 10) begin
            send_stray_beat();
            sent++;
          end
          r = $urandom_range(99);
          if (r < 3) begin
            send_sample(ch, 16'($urandom_range(16'hFFFF)), 1'b1, 1'($urandom_range(1)));
          end else if (r < 5) begin
            send_sample(ch, 16'($urandom_range(16'hFFFF)), 1'b0, 1'b1);
          end else if (r < 8) begin
            // step out of the window on either side
            if ($urandom_range(1))
              send_sample(ch, clamp_sample(anchor + hi + 1 + $urandom_range(40)), 1'b0, 1'b0);
            else
              send_sample(ch, clamp_sample(anchor - lo - 1 - $urandom_range(40)), 1'b0, 1'b0);
          end else if (r < 11) begin
            send_sample(ch, base_mem[ch], 1'b0, 1'b0);
          end else if (k == 0) begin
            send_sample(ch, 16'(anchor), 1'b0, 1'b0);
          end else begin
            send_sample(ch, clamp_sample(anchor - lo + $urandom_range(lo + hi)), 1'b0, 1'b0);
          end
          sent++;
        end
      end
    end
  endtask

  // defaults after reset: long update time, one key in use
  task automatic test_reset_defaults();
    send_sample(4'd0, 16'h1234, 1'b0, 1'b0);
    send_sample(4'd1, 16'hFFFF, 1'b0, 1'b0);
    send_sample(4'd0, 16'h1234, 1'b1, 1'b0);
  endtask

  // zero update time updates on every clean sample, also an unchanged one
  task automatic test_zero_update_time();
    program_config(15, 1, 0, 0, 0);
    send_sample(4'd0, 16'h0000, 1'b0, 1'b0);
    send_sample(4'd15, 16'hFFFF, 1'b0, 1'b0);
    send_sample(4'd7, 16'hAAAA, 1'b1, 1'b0);
    send_sample(4'd8, 16'h5555, 1'b0, 1'b1);
    send_sample(4'd9, 16'h5555, 1'b1, 1'b1);
    send_sample(4'd9, 16'h5555, 1'b0, 1'b0);
  endtask

  // window opening updates at once at 0x81, window edges and restart
  task automatic test_window_restart();
    program_config(15, 1, 5, 5, 8'h81);
    send_sample(4'd2, 16'h0100, 1'b0, 1'b0);
    program_config(15, 1, 5, 5, 8'h83);
    send_sample(4'd2, 16'h0200, 1'b0, 1'b0);
    send_sample(4'd2, 16'h0205, 1'b0, 1'b0);
    send_sample(4'd2, 16'h01FA, 1'b0, 1'b0);
    send_sample(4'd2, 16'h0200, 1'b0, 1'b0);
    send_sample(4'd2, 16'h0203, 1'b0, 1'b0);
    send_sample(4'd2, 16'h01FB, 1'b0, 1'b0);
  endtask

  // channels beyond the active count only report their stored baseline
  task automatic test_inactive_channels();
    program_config(2, 0, 0, 0, 0);
    send_sample(4'd2, 16'h4321, 1'b0, 1'b0);
    send_sample(4'd15, 16'h0000, 1'b0, 1'b0);
    program_config(2, 1, 0, 0, 0);
    send_sample(4'd2, 16'h4321, 1'b0, 1'b0);
  endtask

  // random phases over several register settings and pacing modes
  task automatic test_random_traffic();
    int upd_time;
    for (int p = 0; p < 10; p++) begin
      if (p == 4) set_pacing(75, 9);
      if (p == 7) set_pacing(0, 0);
      if (p == 0) begin
        program_config(15, 1, 255, 255, 255);
      end else if (p == 1) begin
        program_config(1, 0, 0, 0, 0);
      end else begin
        upd_time = ($urandom_range(99) < 70) ? $urandom_range(8'h7C, 8'h8C)
                                             : $urandom_range(255);
        program_config($urandom_range(1, 15), $urandom_range(1),
                       ($urandom_range(1) ? $urandom_range(8) : $urandom_range(255)),
                       ($urandom_range(1) ? $urandom_range(8) : $urandom_range(255)),
                       upd_time);
      end
      run_traffic(155);
    end
  endtask

  // long receiver hold-off while beats keep coming, so the input stalls
  task automatic test_backpressure();
    program_config(15, 1, 4, 4, 8'h84);
    @(posedge clk_i);
    stall_hold <= 48;
    run_traffic(32);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_pacing(9, 75);
    test_reset_defaults();
    test_zero_update_time();
    test_window_restart();
    test_inactive_channels();
    test_random_traffic();
    test_backpressure();
    wait_drained();
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
